// File: sv/tcc_pkg.sv
// Shared types and constants for the time/cycle converter.
`default_nettype none
package tcc_pkg;

  localparam int unsigned ValW  = 64;
  localparam int unsigned FacW  = 32;
  localparam int unsigned ProdW = ValW + FacW;

  localparam logic [FacW-1:0] NS_PER_SEC = 32'd1000000000;
  localparam logic [FacW-1:0] US_PER_SEC = 32'd1000000;
  localparam logic [FacW-1:0] FREQ_RESET = 32'd62500000;

  typedef enum logic [1:0] {
    CMD_NS_TO_CYC = 2'd0,
    CMD_US_TO_CYC = 2'd1,
    CMD_CYC_TO_NS = 2'd2,
    CMD_CYC_TO_US = 2'd3
  } tcc_cmd_e;

  typedef enum logic [1:0] {
    DIV_IDLE = 2'd0,
    DIV_RUN  = 2'd1,
    DIV_HOLD = 2'd2
  } tcc_div_state_e;

  // One queued conversion: full product, divisor and saturation mark.
  typedef struct packed {
    logic [ProdW-1:0] prod;
    logic [FacW-1:0]  divisor;
    logic             sat;
  } tcc_job_t;

endpackage
`default_nettype wire

// File: sv/tcc_front.sv
// Front end: config register, command decode and 64x32 product pipeline.
`default_nettype none
module tcc_front (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_we_i,
  input  wire  [tcc_pkg::FacW-1:0]   cfg_wdata_i,
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  wire  [1:0]                 cmd_i,
  input  wire  [tcc_pkg::ValW-1:0]   value_i,
  output logic                       push_o,
  output tcc_pkg::tcc_job_t          push_job_o,
  input  wire                        full_i
);
  import tcc_pkg::*;

  logic [FacW-1:0] freq_q;

  logic            s1_valid_q, s1_valid_d;
  logic [ValW-1:0] s1_value_q;
  logic [FacW-1:0] s1_mult_q, s1_mult_d;
  logic [FacW-1:0] s1_div_q, s1_div_d;
  logic            s1_sat_q, s1_sat_d;

  logic                 s2_valid_q;
  logic [2*FacW-1:0]    s2_pp_lo_q;
  logic [2*FacW-1:0]    s2_pp_hi_q;
  logic [FacW-1:0]      s2_div_q;
  logic                 s2_sat_q;

  logic     advance;
  tcc_cmd_e cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= FREQ_RESET;
    end else if (cfg_we_i) begin
      freq_q <= cfg_wdata_i;
    end
  end

  assign cmd        = tcc_cmd_e'(cmd_i);
  assign advance    = !(s2_valid_q && full_i);
  assign in_stall_o = !advance;
  assign s1_valid_d = in_valid_i;

  always_comb begin
    s1_mult_d = freq_q;
    s1_div_d  = NS_PER_SEC;
    s1_sat_d  = 1'b0;
    unique case (cmd)
      CMD_NS_TO_CYC: begin
        s1_mult_d = freq_q;
        s1_div_d  = NS_PER_SEC;
      end
      CMD_US_TO_CYC: begin
        s1_mult_d = freq_q;
        s1_div_d  = US_PER_SEC;
      end
      CMD_CYC_TO_NS: begin
        s1_mult_d = NS_PER_SEC;
        s1_div_d  = freq_q;
        s1_sat_d  = (freq_q == '0);
      end
      CMD_CYC_TO_US: begin
        s1_mult_d = US_PER_SEC;
        s1_div_d  = freq_q;
        s1_sat_d  = (freq_q == '0);
      end
      default: begin
        s1_mult_d = freq_q;
        s1_div_d  = NS_PER_SEC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s1_valid_q;
    end
  end

  // Two 32x32 partial products in parallel, summed on the way into the queue.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_value_q <= value_i;
      s1_mult_q  <= s1_mult_d;
      s1_div_q   <= s1_div_d;
      s1_sat_q   <= s1_sat_d;
      s2_pp_lo_q <= {{FacW{1'b0}}, s1_value_q[FacW-1:0]} * {{FacW{1'b0}}, s1_mult_q};
      s2_pp_hi_q <= {{FacW{1'b0}}, s1_value_q[ValW-1:FacW]} * {{FacW{1'b0}}, s1_mult_q};
      s2_div_q   <= s1_div_q;
      s2_sat_q   <= s1_sat_q;
    end
  end

  assign push_o             = s2_valid_q && !full_i;
  assign push_job_o.prod    = {s2_pp_hi_q, {FacW{1'b0}}} + {{FacW{1'b0}}, s2_pp_lo_q};
  assign push_job_o.divisor = s2_div_q;
  assign push_job_o.sat     = s2_sat_q;

endmodule
`default_nettype wire

// File: sv/tcc_fifo.sv
// Job queue between the product front end and the divider.
`default_nettype none
module tcc_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  tcc_pkg::tcc_job_t  push_job_i,
  output logic               full_o,
  input  wire                pop_i,
  output tcc_pkg::tcc_job_t  pop_job_o,
  output logic               empty_o
);
  import tcc_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  tcc_job_t         mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign pop_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/tcc_div.sv
// Back end: radix-2 restoring divider for 96/32 and the output register.
`default_nettype none
module tcc_div (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        empty_i,
  input  tcc_pkg::tcc_job_t          job_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output logic [tcc_pkg::ValW-1:0]   result_o,
  output logic                       overflow_o
);
  import tcc_pkg::*;

  localparam int unsigned CntW = $clog2(ProdW);
  localparam logic [CntW-1:0] StepLast = CntW'(ProdW - 1);

  tcc_div_state_e   state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ProdW-1:0] quo_q, quo_d;
  logic [FacW-1:0]  rem_q, rem_d;
  logic [FacW-1:0]  div_q, div_d;

  logic             out_valid_q, out_valid_d;
  logic [ValW-1:0]  result_q, result_d;
  logic             ovf_q, ovf_d;

  logic [FacW:0]    trial;
  logic [FacW:0]    diff;
  logic             ge;
  logic             out_free;

  assign trial    = {rem_q, quo_q[ProdW-1]};
  assign diff     = trial - {1'b0, div_q};
  assign ge       = (trial >= {1'b0, div_q});
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    div_d       = div_q;
    out_valid_d = out_valid_q;
    result_d    = result_q;
    ovf_d       = ovf_q;
    pop_o       = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      DIV_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          div_d = job_i.divisor;
          rem_d = '0;
          cnt_d = '0;
          // Saturate a zero-divisor job: all-ones quotient flags overflow too.
          if (job_i.sat) begin
            quo_d   = '1;
            state_d = DIV_HOLD;
          end else begin
            quo_d   = job_i.prod;
            state_d = DIV_RUN;
          end
        end
      end
      DIV_RUN: begin
        rem_d = ge ? diff[FacW-1:0] : trial[FacW-1:0];
        quo_d = {quo_q[ProdW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == StepLast) begin
          state_d = DIV_HOLD;
        end
      end
      DIV_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          result_d    = quo_q[ValW-1:0];
          ovf_d       = |quo_q[ProdW-1:ValW];
          state_d     = DIV_IDLE;
        end
      end
      default: begin
        state_d = DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= DIV_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    div_q    <= div_d;
    result_q <= result_d;
    ovf_q    <= ovf_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign overflow_o  = ovf_q;

endmodule
`default_nettype wire

// File: sv/time_cycle_converter_core.sv
// Top level of the time/cycle converter: front end, job queue and divider.
//
//  Channel  Direction  Handshake                 Payload
//  in       input      in_valid_i / in_stall_o   cmd_i, value_i
//  out      output     out_valid_o / out_stall_i result_o, overflow_o
//  cfg      input      cfg_we_i                  cfg_wdata_i
//
// In the divider a conversion is loaded, runs 96 radix-2 restoring steps
// over the 96-bit product and is handed off, after two front-end product
// stages; a zero-frequency cycles-to-time job skips the restoring steps.
// The front end stalls once the job queue is full and a product waits.
// Reset returns the frequency register to 62500000 and empties all stages.
// A stalled output holds its result; the divider waits after finishing.
`default_nettype none
module time_cycle_converter_core #(
  parameter int unsigned FifoDepth = 2
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_we_i,
  input  wire  [tcc_pkg::FacW-1:0]   cfg_wdata_i,
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  wire  [1:0]                 cmd_i,
  input  wire  [tcc_pkg::ValW-1:0]   value_i,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output logic [tcc_pkg::ValW-1:0]   result_o,
  output logic                       overflow_o
);
  import tcc_pkg::*;

  logic     push, full, pop, empty;
  tcc_job_t push_job, pop_job;

  tcc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .value_i    (value_i),
    .push_o     (push),
    .push_job_o (push_job),
    .full_i     (full)
  );

  tcc_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_job_i(push_job),
    .full_o    (full),
    .pop_i     (pop),
    .pop_job_o (pop_job),
    .empty_o   (empty)
  );

  tcc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .job_i      (pop_job),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .result_o   (result_o),
    .overflow_o (overflow_o)
  );

endmodule
`default_nettype wire

// File: sv/tcc_checker.sv
// Port-level checks for the time/cycle converter, bound to the top level.
`default_nettype none
module tcc_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        in_valid_i,
  input wire                        in_stall_o,
  input wire                        out_valid_o,
  input wire                        out_stall_i,
  input wire [tcc_pkg::ValW-1:0]    result_o,
  input wire                        overflow_o
);

  // Hold a stalled result.
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("out_valid_o dropped while stalled");

  a_out_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(result_o) && $stable(overflow_o)))
    else $error("output payload changed while stalled");

  // Reset empties the pipeline and the output register.
  a_reset_clears: assert property (@(posedge clk_i)
    !rst_ni |=> (!out_valid_o && !in_stall_o))
    else $error("block not empty after reset");

  // Input stall needs an earlier accepted transaction or an earlier stall.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ($past(in_stall_o) || $past(in_stall_o, 2) ||
                    $past(in_valid_i && !in_stall_o, 2)))
    else $error("input stall without a pending transaction");

endmodule

bind time_cycle_converter_core tcc_checker u_tcc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .result_o   (result_o),
  .overflow_o (overflow_o)
);
`default_nettype wire

// File: tb/tb_time_cycle_converter_core.sv
// Self-checking testbench for time_cycle_converter_core: random and directed conversions.
module tb_time_cycle_converter_core;
  import tcc_pkg::*;

  typedef struct packed {
    tcc_cmd_e          cmd;
    logic [ValW-1:0]   value;
  } conv_req_t;

  typedef struct packed {
    logic [ValW-1:0]   result;
    logic              overflow;
  } conv_res_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [FacW-1:0]   cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        cmd = CMD_NS_TO_CYC;
  logic [ValW-1:0]   value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ValW-1:0]   result;
  logic              overflow;

  conv_req_t         conv_requests[$];
  conv_res_t         conversions_due[$];
  logic [FacW-1:0]   freq_copy = FREQ_RESET;
  int unsigned       n_queued = 0;
  int unsigned       n_accepted = 0;
  int unsigned       mismatch_cnt = 0;
  bit                in_taken = 1'b0;
  bit                steady_phase = 1'b0;
  bit                hold_req = 1'b0;
  int                gap_left = 0;
  int                stall_left = 0;
  int                free_left = 0;
  conv_req_t         drv_req;
  conv_res_t         due;

  time_cycle_converter_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .cmd_i       (cmd),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .result_o    (result),
    .overflow_o  (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // floor(value * mult / div) over the full product, low 64 bits kept
  function automatic conv_res_t convert_time(tcc_cmd_e c, logic [ValW-1:0] v,
                                             logic [FacW-1:0] f);
    logic [FacW-1:0] mult;
    logic [FacW-1:0] dvsr;
    logic [127:0]    wide_v;
    logic [127:0]    wide_m;
    logic [127:0]    wide_d;
    logic [127:0]    quot;
    conv_res_t       r;
    case (c)
      CMD_NS_TO_CYC: begin mult = f;          dvsr = NS_PER_SEC; end
      CMD_US_TO_CYC: begin mult = f;          dvsr = US_PER_SEC; end
      CMD_CYC_TO_NS: begin mult = NS_PER_SEC; dvsr = f;          end
      default:       begin mult = US_PER_SEC; dvsr = f;          end
    endcase
    if (dvsr == '0) begin
      // saturate: no divide by a zero frequency
      r.result   = '1;
      r.overflow = 1'b1;
    end else begin
      wide_v     = {64'd0, v};
      wide_m     = {96'd0, mult};
      wide_d     = {96'd0, dvsr};
      quot       = (wide_v * wide_m) / wide_d;
      r.result   = quot[63:0];
      r.overflow = |quot[127:64];
    end
    return r;
  endfunction

  // mostly short, a few long
  function automatic int draw_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 8);
  endfunction

  function automatic logic [ValW-1:0] draw_value();
    logic [ValW-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return ValW'($urandom_range(1000));
      3, 4, 5: return v;
      default: return v >> $urandom_range(63);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [ValW-1:0] got, logic [ValW-1:0] want);
    if (mismatch_cnt < 50)
      $display("mismatch on %s at result %0d: got %h, want %h", what, n_accepted, got, want);
    mismatch_cnt++;
  endtask

  task automatic add_conv(tcc_cmd_e c, logic [ValW-1:0] v);
    conv_req_t r;
    r.cmd   = c;
    r.value = v;
    conv_requests.push_back(r);
    n_queued++;
  endtask

  task automatic wait_idle();
    while (n_accepted != n_queued || conversions_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_freq(logic [FacW-1:0] f);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= f;
    freq_copy = f;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random(logic [FacW-1:0] f, int n, bit steady, bit hold);
    write_freq(f);
    steady_phase = steady;
    if (hold) hold_req = 1'b1;
    repeat (n) add_conv(tcc_cmd_e'($urandom_range(3)), draw_value());
    wait_idle();
  endtask

  // Input side: record the transaction and predict its conversion
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      conversions_due.push_back(convert_time(tcc_cmd_e'(cmd), value, freq_copy));
      n_accepted++;
      in_taken = 1'b1;
    end
  end

  // Driver: hold the payload until taken, then advance or idle
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (conv_requests.size() != 0) begin
        drv_req = conv_requests.pop_front();
        cmd      <= drv_req.cmd;
        value    <= drv_req.value;
        in_valid <= 1'b1;
        gap_left = steady_phase ? 0 : draw_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req   = 1'b0;
      stall_left = 600;
      free_left  = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (steady_phase) begin
      out_stall <= 1'b0;
    end else if (free_left > 0) begin
      free_left--;
      out_stall <= 1'b0;
    end else begin
      stall_left = draw_gap();
      free_left  = draw_gap();
      out_stall <= 1'b0;
    end
  end

  // Output side: compare each transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (conversions_due.size() == 0) begin
        report_mismatch("unexpected result", result, '0);
      end else begin
        due = conversions_due.pop_front();
        if (result !== due.result) report_mismatch("result", result, due.result);
        if (overflow !== due.overflow)
          report_mismatch("overflow", ValW'(overflow), ValW'(due.overflow));
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset frequency: extremes of the value for every mode
    for (int c = 0; c < 4; c++) begin
      add_conv(tcc_cmd_e'(c), '0);
      add_conv(tcc_cmd_e'(c), 64'd1);
      add_conv(tcc_cmd_e'(c), '1);
    end
    wait_idle();

    // zero frequency: saturation in cycles-to-time, zero in time-to-cycles
    write_freq('0);
    for (int c = 0; c < 4; c++) begin
      add_conv(tcc_cmd_e'(c), '1);
      add_conv(tcc_cmd_e'(c), 64'h0000_0001_0000_0000);
    end
    wait_idle();

    write_freq('1);
    add_conv(CMD_NS_TO_CYC, '1);
    add_conv(CMD_US_TO_CYC, '1);
    add_conv(CMD_CYC_TO_NS, 64'h8000_0000_0000_0000);
    add_conv(CMD_CYC_TO_US, 64'h0000_0000_FFFF_FFFF);
    wait_idle();

    run_random(32'd1,                  95, 1'b0, 1'b0);
    run_random('1,                     95, 1'b0, 1'b0);
    run_random(NS_PER_SEC,             95, 1'b1, 1'b0);
    run_random(US_PER_SEC,             95, 1'b0, 1'b0);
    run_random(32'd32768,              95, 1'b0, 1'b0);
    run_random(32'd19200000,           95, 1'b1, 1'b1);
    run_random($urandom,               95, 1'b0, 1'b0);
    run_random($urandom,               95, 1'b0, 1'b0);
    run_random('0,                     95, 1'b0, 1'b0);
    run_random(FREQ_RESET,             95, 1'b0, 1'b0);
    run_random($urandom_range(999, 1), 95, 1'b0, 1'b0);

    steady_phase = 1'b0;
    repeat (200) @(negedge clk);
    if (mismatch_cnt == 0 && conversions_due.size() == 0) begin
      $display("[time_cycle_converter_core] OK");
    end else begin
      $display("[time_cycle_converter_core] ERROR");
    end
    $finish;
  end

  initial begin
    #25000000;
    $display("[time_cycle_converter_core] ERROR");
    $finish;
  end

endmodule

// File: time_cycle_converter_core.f
sv/tcc_pkg.sv
sv/tcc_front.sv
sv/tcc_fifo.sv
sv/tcc_div.sv
sv/time_cycle_converter_core.sv
sv/tcc_checker.sv
tb/tb_time_cycle_converter_core.sv
